// ----- rtl/efsd_pkg.sv -----
// Shared constants, types and helpers for the earliest-free server dispatcher.
package efsd_pkg;

  // Server pool size and the widths that follow from it
  localparam int MAX_SERVERS = 16;
  localparam int SRV_IDX_W   = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int SRV_CNT_W   = $clog2(MAX_SERVERS + 1);

  // Field and register widths
  localparam int TOD_W      = 17;  // second of day
  localparam int SVC_CAP_W  = 11;
  localparam int SRV_CFG_W  = 5;
  localparam int HOUR_W     = 5;
  localparam int MIN_W      = 6;
  localparam int SEC_W      = 6;
  localparam int SVC_W      = 16;
  localparam int FREE_W     = 32;
  localparam int SUM_W      = 40;
  localparam int SERVED_W   = 24;
  localparam int OUT_IDX_W  = 4;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;

  // Time conversion
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;

  // Register reset values
  localparam logic [TOD_W-1:0]     OPEN_TIME_RST   = TOD_W'(8 * 60 * 60);
  localparam logic [TOD_W-1:0]     CLOSE_TIME_RST  = TOD_W'(17 * 60 * 60);
  localparam logic [SVC_CAP_W-1:0] MAX_SVC_RST     = SVC_CAP_W'(60);
  localparam logic [SRV_CFG_W-1:0] SERVER_CNT_RST  = SRV_CFG_W'(16);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_TIME    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TIME   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SERVICE  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SERVER_COUNT = CFG_IDX_W'(3);

  // Input item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_JOB   = 1'b1;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CALC   = 6'b000010,
    ST_CHECK  = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  // Sequencer to server table
  typedef struct packed {
    logic                 init;
    logic [TOD_W-1:0]     init_time;
    logic                 scan_start;
    logic                 scan_step;
    logic                 write;
    logic [FREE_W-1:0]    wr_data;
    logic [SRV_CNT_W-1:0] active;
  } srv_ctrl_t;

  // Server table back to the sequencer
  typedef struct packed {
    logic                 done;
    logic [SRV_IDX_W-1:0] best;
    logic [FREE_W-1:0]    best_time;
  } srv_stat_t;

  // Clamp the configured server count into 1..MAX_SERVERS
  function automatic logic [SRV_CNT_W-1:0] active_servers(input logic [SRV_CFG_W-1:0] cnt);
    logic [SRV_CNT_W-1:0] n;
    if (cnt == '0) begin
      n = SRV_CNT_W'(1);
    end else if (32'(cnt) > 32'(MAX_SERVERS)) begin
      n = SRV_CNT_W'(MAX_SERVERS);
    end else begin
      n = SRV_CNT_W'(cnt);
    end
    return n;
  endfunction

endpackage

// ----- rtl/efsd_if.sv -----
// Handshake channel interfaces for job input, dispatch result and configuration.
interface efsd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [efsd_pkg::HOUR_W-1:0]   arrive_hour;
  logic [efsd_pkg::MIN_W-1:0]    arrive_minute;
  logic [efsd_pkg::SEC_W-1:0]    arrive_second;
  logic [efsd_pkg::SVC_W-1:0]    service_minutes;

  modport source (output valid, kind, arrive_hour, arrive_minute, arrive_second,
                  service_minutes, input ready);
  modport sink   (input valid, kind, arrive_hour, arrive_minute, arrive_second,
                  service_minutes, output ready);
endinterface

interface efsd_out_if;
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic [31:0]                    wait_seconds;
  logic [efsd_pkg::OUT_IDX_W-1:0] server_index;
  logic [efsd_pkg::SUM_W-1:0]     total_wait_seconds;
  logic [efsd_pkg::SERVED_W-1:0]  served_count;

  modport source (output valid, accepted, wait_seconds, server_index, total_wait_seconds,
                  served_count, input ready);
  modport sink   (input valid, accepted, wait_seconds, server_index, total_wait_seconds,
                  served_count, output ready);
endinterface

interface efsd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [efsd_pkg::CFG_IDX_W-1:0]  index;
  logic [efsd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/efsd_servers.sv -----
// Server free-time table with a one-entry-per-cycle earliest-free scan.
module efsd_servers (
  input  logic                clk,
  input  logic                rst_n,
  input  efsd_pkg::srv_ctrl_t ctrl,
  output efsd_pkg::srv_stat_t stat
);

  logic [efsd_pkg::FREE_W-1:0]    free_r [efsd_pkg::MAX_SERVERS];
  logic [efsd_pkg::SRV_CNT_W-1:0] idx_r;
  logic [efsd_pkg::SRV_IDX_W-1:0] best_r;
  logic [efsd_pkg::FREE_W-1:0]    best_time_r;
  logic [efsd_pkg::FREE_W-1:0]    cand;
  logic                           cand_less;

  // Compare the current candidate against the running minimum
  assign cand      = free_r[idx_r[efsd_pkg::SRV_IDX_W-1:0]];
  assign cand_less = cand < best_time_r;

  // Scan finishes once every active server has been visited
  assign stat.done      = idx_r >= ctrl.active;
  assign stat.best      = best_r;
  assign stat.best_time = best_time_r;

  // Free-time table: reset, session start and post-dispatch update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < efsd_pkg::MAX_SERVERS; i++) begin
        free_r[i] <= '0;
      end
    end else if (ctrl.init) begin
      for (int i = 0; i < efsd_pkg::MAX_SERVERS; i++) begin
        free_r[i] <= efsd_pkg::FREE_W'(ctrl.init_time);
      end
    end else if (ctrl.write) begin
      free_r[best_r] <= ctrl.wr_data;
    end
  end

  // Scan pointer and running minimum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      best_r      <= '0;
      best_time_r <= '0;
    end else if (ctrl.scan_start) begin
      idx_r       <= efsd_pkg::SRV_CNT_W'(1);
      best_r      <= '0;
      best_time_r <= free_r[0];
    end else if (ctrl.scan_step) begin
      idx_r <= idx_r + efsd_pkg::SRV_CNT_W'(1);
      if (cand_less) begin
        best_r      <= idx_r[efsd_pkg::SRV_IDX_W-1:0];
        best_time_r <= cand;
      end
    end
  end

endmodule

// ----- rtl/earliest_free_server_dispatch.sv -----
// Top level: dispatches each job to the earliest-free server and keeps the totals.
//
//  channel | dir | handshake    | carries
//  in_if   | in  | valid/ready  | kind, arrival hour/minute/second, service minutes
//  out_if  | out | valid/ready  | accepted, wait, server index, total wait, served count
//  cfg_if  | in  | valid/ready  | register index, write data (always ready)
//
// One transaction in, one out. A start item goes from IDLE straight to DONE, where the
// result is offered. A job passes through CALC and CHECK; a rejected job then goes to
// DONE, while a served job scans the free-time table in SCAN, one entry per cycle
// through a single comparator over the active servers, then updates the chosen
// server in UPDATE before DONE.
// in_if.ready is low from acceptance until the result has been taken.
// Reset (rst_n, synchronous) restores registers, clears totals and free times.
module earliest_free_server_dispatch (
  input  logic   clk,
  input  logic   rst_n,
  efsd_in_if.sink    in_if,
  efsd_out_if.source out_if,
  efsd_cfg_if.sink   cfg_if
);

  efsd_pkg::state_t state_r, state_nxt;

  // Configuration registers
  logic [efsd_pkg::TOD_W-1:0]     open_time_r;
  logic [efsd_pkg::TOD_W-1:0]     close_time_r;
  logic [efsd_pkg::SVC_CAP_W-1:0] max_svc_r;
  logic [efsd_pkg::SRV_CFG_W-1:0] server_cnt_r;

  // Captured transaction and derived values
  logic [efsd_pkg::HOUR_W-1:0]    hour_r;
  logic [efsd_pkg::MIN_W-1:0]     minute_r;
  logic [efsd_pkg::SEC_W-1:0]     second_r;
  logic [efsd_pkg::SVC_W-1:0]     svc_in_r;
  logic [efsd_pkg::TOD_W-1:0]     arrive_r;
  logic [efsd_pkg::SVC_CAP_W-1:0] svc_r;

  // Totals and result registers
  logic [efsd_pkg::SUM_W-1:0]     sum_r;
  logic [efsd_pkg::SERVED_W-1:0]  served_r;
  logic                           acc_r;
  logic [31:0]                    wait_r;
  logic [efsd_pkg::OUT_IDX_W-1:0] idx_out_r;

  efsd_pkg::srv_ctrl_t ctrl;
  efsd_pkg::srv_stat_t stat;

  logic                          in_fire;
  logic                          out_fire;
  logic [efsd_pkg::FREE_W-1:0]   arrive_ext;
  logic                          late_start;
  logic [efsd_pkg::FREE_W-1:0]   wait_val;
  logic [efsd_pkg::FREE_W-1:0]   start_val;
  logic [efsd_pkg::FREE_W:0]     fin_full;
  logic [efsd_pkg::FREE_W-1:0]   fin_val;
  logic [efsd_pkg::SUM_W:0]      sum_full;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;

  assign in_if.ready  = (state_r == efsd_pkg::ST_IDLE);
  assign cfg_if.ready = 1'b1;

  // Wait, service start and new free time from the chosen server
  assign arrive_ext = efsd_pkg::FREE_W'(arrive_r);
  assign late_start = stat.best_time > arrive_ext;
  assign wait_val   = late_start ? (stat.best_time - arrive_ext) : '0;
  assign start_val  = late_start ? stat.best_time : arrive_ext;
  assign fin_full   = {1'b0, start_val}
                    + (33'(svc_r) * 33'(efsd_pkg::SECS_PER_MIN));
  assign fin_val    = fin_full[efsd_pkg::FREE_W] ? '1 : fin_full[efsd_pkg::FREE_W-1:0];
  assign sum_full   = {1'b0, sum_r} + 41'(wait_val);

  // Drive the server table
  always_comb begin
    ctrl            = '0;
    ctrl.init       = in_fire && (in_if.kind == efsd_pkg::KIND_START);
    ctrl.init_time  = open_time_r;
    ctrl.scan_start = (state_r == efsd_pkg::ST_CHECK);
    ctrl.scan_step  = (state_r == efsd_pkg::ST_SCAN) && !stat.done;
    ctrl.write      = (state_r == efsd_pkg::ST_UPDATE);
    ctrl.wr_data    = fin_val;
    ctrl.active     = efsd_pkg::active_servers(server_cnt_r);
  end

  efsd_servers u_servers (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      efsd_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_if.kind == efsd_pkg::KIND_START) ? efsd_pkg::ST_DONE
                                                           : efsd_pkg::ST_CALC;
        end
      end
      efsd_pkg::ST_CALC:  state_nxt = efsd_pkg::ST_CHECK;
      efsd_pkg::ST_CHECK: begin
        state_nxt = (arrive_r > close_time_r) ? efsd_pkg::ST_DONE : efsd_pkg::ST_SCAN;
      end
      efsd_pkg::ST_SCAN: begin
        if (stat.done) begin
          state_nxt = efsd_pkg::ST_UPDATE;
        end
      end
      efsd_pkg::ST_UPDATE: state_nxt = efsd_pkg::ST_DONE;
      efsd_pkg::ST_DONE: begin
        if (out_fire) begin
          state_nxt = efsd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = efsd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= efsd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_time_r  <= efsd_pkg::OPEN_TIME_RST;
      close_time_r <= efsd_pkg::CLOSE_TIME_RST;
      max_svc_r    <= efsd_pkg::MAX_SVC_RST;
      server_cnt_r <= efsd_pkg::SERVER_CNT_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        efsd_pkg::REG_OPEN_TIME:    open_time_r  <= cfg_if.data;
        efsd_pkg::REG_CLOSE_TIME:   close_time_r <= cfg_if.data;
        efsd_pkg::REG_MAX_SERVICE:  max_svc_r    <= cfg_if.data[efsd_pkg::SVC_CAP_W-1:0];
        efsd_pkg::REG_SERVER_COUNT: server_cnt_r <= cfg_if.data[efsd_pkg::SRV_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the transaction, then form arrival second and capped service
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hour_r   <= in_if.arrive_hour;
      minute_r <= in_if.arrive_minute;
      second_r <= in_if.arrive_second;
      svc_in_r <= in_if.service_minutes;
    end
    if (state_r == efsd_pkg::ST_CALC) begin
      arrive_r <= efsd_pkg::TOD_W'(hour_r) * efsd_pkg::TOD_W'(efsd_pkg::SECS_PER_HOUR)
                + efsd_pkg::TOD_W'(minute_r) * efsd_pkg::TOD_W'(efsd_pkg::SECS_PER_MIN)
                + efsd_pkg::TOD_W'(second_r);
      svc_r    <= (svc_in_r > efsd_pkg::SVC_W'(max_svc_r)) ? max_svc_r
                                                           : svc_in_r[efsd_pkg::SVC_CAP_W-1:0];
    end
  end

  // Totals: clear on session start, saturate on each served job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      served_r <= '0;
    end else if (ctrl.init) begin
      sum_r    <= '0;
      served_r <= '0;
    end else if (state_r == efsd_pkg::ST_UPDATE) begin
      sum_r <= sum_full[efsd_pkg::SUM_W] ? '1 : sum_full[efsd_pkg::SUM_W-1:0];
      if (served_r != '1) begin
        served_r <= served_r + efsd_pkg::SERVED_W'(1);
      end
    end
  end

  // Result register: zero for starts and rejects, filled on dispatch
  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc_r     <= 1'b0;
      wait_r    <= '0;
      idx_out_r <= '0;
    end else if (state_r == efsd_pkg::ST_UPDATE) begin
      acc_r     <= 1'b1;
      wait_r    <= wait_val;
      idx_out_r <= efsd_pkg::OUT_IDX_W'(stat.best);
    end
  end

  assign out_if.valid              = (state_r == efsd_pkg::ST_DONE);
  assign out_if.accepted           = acc_r;
  assign out_if.wait_seconds       = wait_r;
  assign out_if.server_index       = idx_out_r;
  assign out_if.total_wait_seconds = sum_r;
  assign out_if.served_count       = served_r;

  // Checks
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_if.valid && in_if.ready))
    else $error("new transaction offered while a result is pending");

  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_if.kind == efsd_pkg::KIND_START) |=>
      (out_if.valid && !out_if.accepted && out_if.served_count == '0
       && out_if.total_wait_seconds == '0))
    else $error("start transaction did not give a cleared result");

  a_served_step: assert property (@(posedge clk) disable iff (!rst_n)
    (served_r != $past(served_r)) |->
      (served_r == $past(served_r) + efsd_pkg::SERVED_W'(1) || served_r == '0))
    else $error("served count moved by other than one");

  a_accept_has_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == efsd_pkg::ST_UPDATE) |-> $past(state_r == efsd_pkg::ST_SCAN && stat.done))
    else $error("dispatch update without a finished scan");

endmodule

// ----- tb/sv/earliest_free_server_dispatch_test.sv -----
// Self-checking testbench for the earliest-free server dispatcher.
module earliest_free_server_dispatch_test;
  import efsd_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_PAD    = 32;    // idle pad after the last pending result
  localparam int STALL_LIMIT  = 4000;  // cycles with no transaction on any channel
  localparam int RANDOM_ITEMS = 1830;
  localparam int PHASES       = 8;
  localparam int REPORT_LIMIT = 10;
  localparam int LAST_ARRIVAL = 31 * 3600 + 59 * 60 + 59;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(8'hA5);
  localparam logic [FREE_W-1:0]    FREE_LIMIT   = '1;
  localparam logic [SUM_W-1:0]     SUM_LIMIT    = '1;
  localparam logic [SERVED_W-1:0]  SERVED_LIMIT = '1;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  typedef struct {
    logic              kind;
    logic [HOUR_W-1:0] arrive_hour;
    logic [MIN_W-1:0]  arrive_minute;
    logic [SEC_W-1:0]  arrive_second;
    logic [SVC_W-1:0]  service_minutes;
  } job_item_t;

  typedef struct {
    logic                 accepted;
    logic [31:0]          wait_seconds;
    logic [OUT_IDX_W-1:0] server_index;
    logic [SUM_W-1:0]     total_wait_seconds;
    logic [SERVED_W-1:0]  served_count;
  } dispatch_result_t;

  // Mirror of the dispatcher: server free times, totals and registers
  class dispatch_scoreboard;
    logic [FREE_W-1:0]    free_time [MAX_SERVERS];
    logic [SUM_W-1:0]     wait_total;
    logic [SERVED_W-1:0]  jobs_done;
    logic [TOD_W-1:0]     open_t;
    logic [TOD_W-1:0]     close_t;
    logic [SVC_CAP_W-1:0] svc_cap;
    logic [SRV_CFG_W-1:0] srv_cfg;
    dispatch_result_t     due_q[$];
    int                   faults;

    function new();
      foreach (free_time[i]) free_time[i] = '0;
      wait_total = '0;
      jobs_done  = '0;
      open_t     = OPEN_TIME_RST;
      close_t    = CLOSE_TIME_RST;
      svc_cap    = MAX_SVC_RST;
      srv_cfg    = SERVER_CNT_RST;
      faults     = 0;
    endfunction

    function int active_count();
      if (srv_cfg == '0) return 1;
      if (int'(srv_cfg) > MAX_SERVERS) return MAX_SERVERS;
      return int'(srv_cfg);
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_OPEN_TIME:    open_t  = data[TOD_W-1:0];
        REG_CLOSE_TIME:   close_t = data[TOD_W-1:0];
        REG_MAX_SERVICE:  svc_cap = data[SVC_CAP_W-1:0];
        REG_SERVER_COUNT: srv_cfg = data[SRV_CFG_W-1:0];
        default: ;
      endcase
    endfunction

    // Work out the result of one accepted item and queue it
    function void note_item(job_item_t it);
      dispatch_result_t r;
      longint unsigned  arrive, svc, begin_at, fin, delay, tot;
      int               n, best;
      r.accepted     = 1'b0;
      r.wait_seconds = '0;
      r.server_index = '0;
      if (it.kind == KIND_START) begin
        foreach (free_time[i]) free_time[i] = FREE_W'(open_t);
        wait_total = '0;
        jobs_done  = '0;
      end else begin
        arrive = 64'(it.arrive_hour) * SECS_PER_HOUR + 64'(it.arrive_minute) * SECS_PER_MIN
               + 64'(it.arrive_second);
        if (arrive <= 64'(close_t)) begin
          svc = 64'(it.service_minutes);
          if (svc > 64'(svc_cap)) svc = 64'(svc_cap);
          n    = active_count();
          best = 0;
          for (int i = 1; i < n; i++)
            if (free_time[i] < free_time[best]) best = i;
          begin_at = 64'(free_time[best]);
          delay    = 0;
          if (begin_at > arrive) delay = begin_at - arrive;
          else begin_at = arrive;
          fin = begin_at + svc * SECS_PER_MIN;
          if (fin > 64'(FREE_LIMIT)) fin = 64'(FREE_LIMIT);
          free_time[best] = FREE_W'(fin);
          tot = 64'(wait_total) + delay;
          if (tot > 64'(SUM_LIMIT)) tot = 64'(SUM_LIMIT);
          wait_total = SUM_W'(tot);
          if (jobs_done != SERVED_LIMIT) jobs_done = jobs_done + 1'b1;
          r.accepted     = 1'b1;
          r.wait_seconds = 32'(delay);
          r.server_index = OUT_IDX_W'(best);
        end
      end
      r.total_wait_seconds = wait_total;
      r.served_count       = jobs_done;
      due_q.push_back(r);
    endfunction

    // Compare one delivered result with the oldest pending one
    function void check_result(dispatch_result_t got);
      dispatch_result_t want;
      if (due_q.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("result with nothing pending: acc=%0d wait=%0d srv=%0d total=%0d served=%0d",
                   got.accepted, got.wait_seconds, got.server_index,
                   got.total_wait_seconds, got.served_count);
        return;
      end
      want = due_q.pop_front();
      if (got.accepted !== want.accepted || got.wait_seconds !== want.wait_seconds ||
          got.server_index !== want.server_index ||
          got.total_wait_seconds !== want.total_wait_seconds ||
          got.served_count !== want.served_count) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("mismatch: exp acc=%0d wait=%0d srv=%0d total=%0d served=%0d",
                   want.accepted, want.wait_seconds, want.server_index,
                   want.total_wait_seconds, want.served_count,
                   " | got acc=%0d wait=%0d srv=%0d total=%0d served=%0d",
                   got.accepted, got.wait_seconds, got.server_index,
                   got.total_wait_seconds, got.served_count);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  efsd_in_if  in_if();
  efsd_out_if out_if();
  efsd_cfg_if cfg_if();

  earliest_free_server_dispatch dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  dispatch_scoreboard sb = new();

  int quiet_cycles = 0;
  int recv_cycle   = 0;
  int items_sent   = 0;
  int burst_left   = 0;
  int pause_at     = -1;

  always #(HALF_PERIOD) clk = ~clk;

  // Stall the result channel on a rotating pattern
  always @(negedge clk) begin
    recv_cycle = recv_cycle + 1;
    case (rx_mode_e'((recv_cycle / 300) % 4))
      RX_ALWAYS:   out_if.ready = 1'b1;
      RX_COIN:     out_if.ready = 1'($urandom_range(0, 1));
      RX_PERIODIC: out_if.ready = (recv_cycle % 7) >= 3;
      default:     out_if.ready = ($urandom_range(0, 7) != 0);
    endcase
  end

  // Check every result transaction
  always @(posedge clk) begin : take_result
    dispatch_result_t got;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.accepted           = out_if.accepted;
      got.wait_seconds       = out_if.wait_seconds;
      got.server_index       = out_if.server_index;
      got.total_wait_seconds = out_if.total_wait_seconds;
      got.served_count       = out_if.served_count;
      sb.check_result(got);
    end
  end

  // Count cycles without any transaction
  always @(posedge clk) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  function automatic job_item_t start_item();
    job_item_t it;
    it.kind            = KIND_START;
    it.arrive_hour     = '0;
    it.arrive_minute   = '0;
    it.arrive_second   = '0;
    it.service_minutes = '0;
    return it;
  endfunction

  function automatic job_item_t job_at(int hh, int mm, int ss, int svc);
    job_item_t it;
    it.kind            = KIND_JOB;
    it.arrive_hour     = HOUR_W'(hh);
    it.arrive_minute   = MIN_W'(mm);
    it.arrive_second   = SEC_W'(ss);
    it.service_minutes = SVC_W'(svc);
    return it;
  endfunction

  // Offer one item, hold it until taken, then continue the burst or pause
  task automatic push_item(input job_item_t it);
    @(negedge clk);
    in_if.kind            = it.kind;
    in_if.arrive_hour     = it.arrive_hour;
    in_if.arrive_minute   = it.arrive_minute;
    in_if.arrive_second   = it.arrive_second;
    in_if.service_minutes = it.service_minutes;
    in_if.valid           = 1'b1;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_item(it);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_if.valid = 1'b0;
      repeat ($urandom_range(0, 24)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(0, 7);
    end
  endtask

  // Drop valid and wait until every pending result has been delivered
  task automatic wait_drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_if.index = idx;
    cfg_if.data  = val;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    sb.note_config(idx, val);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] open_v,
                                input logic [CFG_DATA_W-1:0] close_v,
                                input logic [CFG_DATA_W-1:0] cap_v,
                                input logic [CFG_DATA_W-1:0] count_v);
    wait_drain();
    write_reg(REG_OPEN_TIME, open_v);
    write_reg(REG_CLOSE_TIME, close_v);
    write_reg(REG_MAX_SERVICE, cap_v);
    write_reg(REG_SERVER_COUNT, count_v);
  endtask

  // One session: a start, then jobs in arrival order with some noise mixed in
  task automatic run_session(input int limit);
    job_item_t it;
    int        t, gap_max, jobs, roll, svc;
    gap_max = ((int'(sb.svc_cap) + 1) * 120) / sb.active_count() + 1;
    if ($urandom_range(0, 2) == 0) gap_max = gap_max / 4 + 1;
    if (int'(sb.open_t) > 1800) t = int'(sb.open_t) - $urandom_range(0, 1800);
    else t = $urandom_range(0, 600);
    jobs = $urandom_range(10, 60);
    push_item(start_item());
    for (int j = 0; j < jobs && items_sent < limit; j++) begin
      if (items_sent == pause_at) wait_drain();
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        it.kind            = 1'($urandom_range(0, 1));
        it.arrive_hour     = HOUR_W'($urandom_range(0, 31));
        it.arrive_minute   = MIN_W'($urandom_range(0, 63));
        it.arrive_second   = SEC_W'($urandom_range(0, 63));
        it.service_minutes = SVC_W'($urandom_range(0, 65535));
        push_item(it);
      end else if (roll < 11) begin
        push_item(start_item());
      end else begin
        t = t + $urandom_range(0, gap_max);
        if (t > LAST_ARRIVAL) t = LAST_ARRIVAL;
        roll = $urandom_range(0, 99);
        if (roll < 70) svc = $urandom_range(0, int'(sb.svc_cap) + 3);
        else if (roll < 85) svc = 0;
        else svc = $urandom_range(0, 65535);
        push_item(job_at(t / 3600, (t % 3600) / 60, t % 60, svc));
      end
    end
  endtask

  // Short directed list: pre-start jobs, ties, waits, close edges, caps
  task automatic run_directed();
    push_item(job_at(9, 0, 0, 30));
    push_item(job_at(9, 0, 0, 0));
    push_item(start_item());
    push_item(job_at(7, 0, 0, 65535));
    push_item(job_at(0, 0, 0, 0));
    push_item(job_at(8, 0, 0, 1));
    push_item(job_at(17, 0, 0, 10));
    push_item(job_at(17, 0, 1, 5));
    push_item(job_at(31, 63, 63, 65535));
    push_item(job_at(16, 59, 59, 60));
    wait_drain();
    write_reg(REG_UNMAPPED, 17'h1ABCD);
    apply_settings(17'h1FFFF, 17'h1FFFF, 17'd0, 17'd0);
    push_item(start_item());
    push_item(job_at(23, 59, 59, 100));
    push_item(job_at(31, 63, 63, 65535));
    apply_settings(17'd0, 17'd86399, 17'd1440, 17'd1);
    push_item(start_item());
    push_item(job_at(0, 0, 0, 1440));
    push_item(job_at(0, 0, 0, 1440));
    push_item(job_at(23, 59, 59, 2000));
  endtask

  initial begin
    int target;
    in_if.valid           = 1'b0;
    in_if.kind            = KIND_START;
    in_if.arrive_hour     = '0;
    in_if.arrive_minute   = '0;
    in_if.arrive_second   = '0;
    in_if.service_minutes = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = REG_OPEN_TIME;
    cfg_if.data           = '0;
    out_if.ready          = 1'b0;
    rst_n                 = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();

    // Sweep register settings, extremes first, then random ones
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_settings(17'(OPEN_TIME_RST), 17'(CLOSE_TIME_RST), 17'(MAX_SVC_RST),
                          17'(SERVER_CNT_RST));
        1: apply_settings(17'd0, 17'd86399, 17'd1440, 17'd1);
        2: apply_settings(17'd3600, 17'd7200, 17'd0, 17'd0);
        3: apply_settings(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        4: apply_settings(17'd0, 17'd0, 17'd15, 17'd3);
        default: apply_settings(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
      endcase
      target   = items_sent + RANDOM_ITEMS / PHASES;
      pause_at = items_sent + $urandom_range(20, RANDOM_ITEMS / PHASES - 20);
      while (items_sent < target) run_session(target);
    end

    wait_drain();
    if (sb.faults == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/efsd_pkg.sv
rtl/efsd_if.sv
rtl/efsd_servers.sv
rtl/earliest_free_server_dispatch.sv
tb/sv/earliest_free_server_dispatch_test.sv
